FILE: design/lpht_pkg.sv
// Shared constants and codes for the linear-probe hash table.
// Used by the table RTL and by its port checker; depends on nothing.
package lpht_pkg;

   localparam int TABLE_DEPTH_DEF   = 128;
   localparam int MAX_KEY_BYTES_DEF = 8;
   localparam int VALUE_BITS_DEF    = 10;

   localparam logic [7:0] TABLE_SIZE_RESET = 8'd127;

   localparam int FOUND_BITS = 11;
   localparam int PROBE_BITS = 8;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_TOO_LONG  = 2'd3
   } status_type;

endpackage

FILE: design/lpht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/linear_probe_hash_table.sv
// Linear-probe hash table fed one key byte per item; top level.
// Depends on lpht_pkg and lpht_ram (slot store: used, length, key, value).
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata key_char, store_value; tuser mode; tlast
//  rsp     | out | rsp_tvalid/tready    | tdata found_value, probe_count, max_probes; tuser status
//  csr     | in  | csr_valid/csr_ready  | csr_wdata table_size
//
// Each byte is accepted in S_IDLE, then takes QB restoring-division steps in S_HASH for
// the hash reduction (QB = 12 at the default depth).
// A last byte then probes slots one at a time through the RAM read port, except for an
// overlong key, and then loads the response register.
// After reset a clearing pass writes every slot empty, with no item accepted;
// csr writes are taken at all times.
// A waiting response does not stall the next item until the next last byte ends.
module linear_probe_hash_table #(
   parameter int TABLE_DEPTH   = lpht_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_KEY_BYTES = lpht_pkg::MAX_KEY_BYTES_DEF,
   parameter int VALUE_BITS    = lpht_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] key_char, [17:8] store_value, [23:18] zero
   input  logic        req_tuser,   // [0] mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] found_value, [18:11] probe_count,
                                    // [26:19] max_probes, [31:27] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   localparam int AB   = $clog2(TABLE_DEPTH);
   localparam int NB   = $clog2(TABLE_DEPTH + 1);
   localparam int KB   = 8 * MAX_KEY_BYTES;
   localparam int CB   = $clog2(MAX_KEY_BYTES + 2);
   localparam int VMAX = 31 * (TABLE_DEPTH - 1) + 255;
   localparam int VB   = $clog2(VMAX + 1);
   localparam int QB   = $clog2(VMAX / 2 + 1);
   localparam int SB   = $clog2(QB);
   localparam int DW   = VB + QB;
   localparam int W    = 1 + CB + KB + VALUE_BITS;
   localparam int FB   = lpht_pkg::FOUND_BITS;
   localparam int PB   = lpht_pkg::PROBE_BITS;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_HASH  = 5'b00100,
      S_CHECK = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [7:0]           table_size_ff, table_size_in;
   logic [KB-1:0]        key_ff, key_in;
   logic [CB-1:0]        cnt_ff, cnt_in;
   logic [AB-1:0]        hash_ff, hash_in;
   logic                 mode_ff, mode_in;
   logic                 last_ff, last_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VB-1:0]        rem_ff, rem_in;
   logic [SB-1:0]        step_ff, step_in;
   logic [AB-1:0]        idx_ff, idx_in;
   logic [NB-1:0]        k_ff, k_in;
   logic [AB-1:0]        clr_ff, clr_in;
   logic [7:0]           worst_ff, worst_in;
   logic [FB-1:0]        res_found_ff, res_found_in;
   logic [PB-1:0]        res_probe_ff, res_probe_in;
   lpht_pkg::status_type res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;

   logic                 wr_en, rd_en;
   logic [AB-1:0]        wr_addr, rd_addr;
   logic [W-1:0]         wr_data, rd_data;

   logic [NB-1:0]        eff_n;
   logic [VALUE_BITS-1:0] req_val;
   logic [FB-1:0]        slot_found;
   logic                 req_fire;
   logic [VB-1:0]        hash_mix;
   logic [DW-1:0]        div_shift;
   logic                 slot_used;
   logic [CB-1:0]        slot_len;
   logic [KB-1:0]        slot_key;
   logic [VALUE_BITS-1:0] slot_val;
   logic                 slot_match;
   logic [AB-1:0]        idx_next;

   function automatic logic [PB-1:0] sat8(input logic [31:0] v);
      logic [PB-1:0] r;
      r = (v > 32'd255) ? 8'd255 : PB'(v);
      return r;
   endfunction

   for (genvar i = 0; i < VALUE_BITS; i++) begin : g_req_val
      if (i < 10) begin : g_bit
         assign req_val[i] = req_tdata[8 + i];
      end else begin : g_zero
         assign req_val[i] = 1'b0;
      end
   end

   for (genvar i = 0; i < FB; i++) begin : g_found
      if (i < VALUE_BITS) begin : g_bit
         assign slot_found[i] = slot_val[i];
      end else begin : g_zero
         assign slot_found[i] = 1'b0;
      end
   end

   assign slot_val   = rd_data[VALUE_BITS-1:0];
   assign slot_key   = rd_data[VALUE_BITS +: KB];
   assign slot_len   = rd_data[VALUE_BITS + KB +: CB];
   assign slot_used  = rd_data[W-1];
   assign slot_match = slot_used && (slot_key == key_ff) && (slot_len == cnt_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      if (32'(table_size_ff) < 32'd2) begin
         eff_n = NB'(2);
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         eff_n = NB'(TABLE_DEPTH);
      end else begin
         eff_n = NB'(table_size_ff);
      end
   end

   assign hash_mix  = (VB'(hash_ff) << 5) - VB'(hash_ff) + VB'(req_tdata[7:0]);
   assign div_shift = DW'(eff_n) << step_ff;
   assign idx_next  = (32'(idx_ff) + 32'd1 == 32'(eff_n)) ? '0 : AB'(idx_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      table_size_in = table_size_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      hash_in       = hash_ff;
      mode_in       = mode_ff;
      last_in       = last_ff;
      val_in        = val_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      clr_in        = clr_ff;
      worst_in      = worst_ff;
      res_found_in  = res_found_ff;
      res_probe_in  = res_probe_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {1'b1, cnt_ff, key_ff, val_ff};
      rd_en         = 1'b0;
      rd_addr       = idx_next;

      if (csr_valid && csr_ready) begin
         table_size_in = csr_wdata;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = AB'(clr_ff + 1'b1);
            if (32'(clr_ff) == TABLE_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               mode_in = req_tuser;
               last_in = req_tlast;
               val_in  = req_val;
               rem_in  = hash_mix;
               step_in = SB'(QB - 1);
               if (32'(cnt_ff) < MAX_KEY_BYTES) begin
                  key_in = KB'({key_ff, req_tdata[7:0]});
                  cnt_in = CB'(cnt_ff + 1'b1);
               end else begin
                  cnt_in = CB'(MAX_KEY_BYTES + 1);
               end
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (DW'(rem_ff) >= div_shift) begin
               rem_in = VB'(DW'(rem_ff) - div_shift);
            end
            step_in = SB'(step_ff - 1'b1);
            if (step_ff == '0) begin
               hash_in = AB'(rem_in);
               if (!last_ff) begin
                  state_in = S_IDLE;
               end else if (32'(cnt_ff) > MAX_KEY_BYTES) begin
                  res_found_in  = '1;
                  res_probe_in  = '0;
                  res_status_in = lpht_pkg::ST_TOO_LONG;
                  key_in        = '0;
                  cnt_in        = '0;
                  hash_in       = '0;
                  state_in      = S_RESP;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AB'(rem_in);
                  idx_in   = AB'(rem_in);
                  k_in     = '0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            res_found_in  = '1;
            res_probe_in  = sat8(32'(k_ff));
            res_status_in = lpht_pkg::ST_OK;
            if (!slot_used) begin
               if (mode_ff == lpht_pkg::MODE_INSERT) begin
                  wr_en = 1'b1;
                  if (32'(k_ff) > 32'(worst_ff)) begin
                     worst_in = sat8(32'(k_ff));
                  end
               end else begin
                  res_status_in = lpht_pkg::ST_NOT_FOUND;
               end
               state_in = S_RESP;
            end else if (mode_ff == lpht_pkg::MODE_LOOKUP && slot_match) begin
               res_found_in = slot_found;
               state_in     = S_RESP;
            end else if (NB'(k_ff + 1'b1) == eff_n) begin
               res_probe_in  = sat8(32'(eff_n));
               res_status_in = lpht_pkg::ST_FULL;
               state_in      = S_RESP;
            end else begin
               rd_en  = 1'b1;
               idx_in = idx_next;
               k_in   = NB'(k_ff + 1'b1);
            end
            if (state_in == S_RESP) begin
               key_in  = '0;
               cnt_in  = '0;
               hash_in = '0;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, worst_ff, res_probe_ff, res_found_ff};
               rsp_user_in  = res_status_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         table_size_ff <= lpht_pkg::TABLE_SIZE_RESET;
         key_ff        <= '0;
         cnt_ff        <= '0;
         hash_ff       <= '0;
         clr_ff        <= '0;
         worst_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         key_ff        <= key_in;
         cnt_ff        <= cnt_in;
         hash_ff       <= hash_in;
         clr_ff        <= clr_in;
         worst_ff      <= worst_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      last_ff       <= last_in;
      val_ff        <= val_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      res_found_ff  <= res_found_in;
      res_probe_ff  <= res_probe_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   lpht_ram #(
      .WIDTH (W),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: design/lpht_checker.sv
// Port-level checker for the linear-probe hash table, with its bind statement.
// Depends on lpht_pkg; watches only the top level's ports.
module lpht_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic [7:0] last_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_max_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_max_ff <= rsp_tdata[26:19];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != lpht_pkg::ST_OK |-> rsp_tdata[10:0] == 11'h7FF)
      else $error("failing status with a found value");

   a_too_long_probes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lpht_pkg::ST_TOO_LONG |-> rsp_tdata[18:11] == 8'd0)
      else $error("overlong key reported probes");

   a_max_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[26:19] >= last_max_ff)
      else $error("max probe count decreased");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
